/* sv/rv64se_pkg.sv */
// Shared constants, codes and types of the RV64I-subset execute unit.
package rv64se_pkg;

	// Data memory size in bytes, a power of two from 16 to 65536.
	localparam int unsigned DATA_BYTES   = 65536;
	localparam int unsigned ADDR_W       = $clog2(DATA_BYTES);
	localparam int unsigned ROWS         = DATA_BYTES / 8;
	localparam int unsigned ROW_W        = ADDR_W - 3;
	localparam int unsigned NREGS        = 32;
	// Reset sweep covers every data row and every register.
	localparam int unsigned CLEAR_CYCLES = (ROWS > NREGS) ? ROWS : NREGS;
	localparam int unsigned CLR_W        = $clog2(CLEAR_CYCLES);
	localparam int unsigned OUTQ_DEPTH   = 4;
	localparam int unsigned OUTQ_PW      = $clog2(OUTQ_DEPTH);
	localparam int unsigned CNT_W        = $clog2(OUTQ_DEPTH + 1);
	localparam logic [63:0] EA_LIMIT     = 64'(DATA_BYTES - 8);

	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] F7_ZERO   = 7'h00;
	localparam logic [6:0] F7_SUB    = 7'h20;
	localparam logic [2:0] F3_ADD    = 3'h0;
	localparam logic [2:0] F3_SLLI   = 3'h1;
	localparam logic [2:0] F3_DWORD  = 3'h3;
	localparam logic [2:0] F3_BEQ    = 3'h0;
	localparam logic [2:0] F3_BLT    = 3'h4;

	typedef enum logic [1:0] {
		KIND_EXEC    = 2'd0,
		KIND_PRELOAD = 2'd1,
		KIND_SETPC   = 2'd2,
		KIND_RSVD    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_EXEC  = 3'd0,
		ST_TAKEN = 3'd1,
		ST_HALT  = 3'd2,
		ST_UNSUP = 3'd3,
		ST_FAULT = 3'd4,
		ST_DONE  = 3'd5
	} status_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [63:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [63:0]       data;
	} dmem_req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] next_pc;
		logic        reg_written;
		logic [4:0]  dest_index;
		logic [63:0] dest_value;
	} res_t;

endpackage

/* sv/rv64se_regfile.sv */
// Register file: 32 x 64 bits, one write port, two registered read ports.
module rv64se_regfile (
	input  logic               clk,
	input  rv64se_pkg::rf_wr_t wr,
	input  logic [4:0]         ra,
	input  logic [4:0]         rb,
	output logic [63:0]        rda,
	output logic [63:0]        rdb
);

	logic [63:0] mem [rv64se_pkg::NREGS];

	// read-first: a same-edge write is seen through the forwarding path upstream
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		rda <= mem[ra];
		rdb <= mem[rb];
	end

endmodule

/* sv/rv64se_dmem.sv */
// Byte-addressed data memory: eight byte banks, unaligned doubleword access.
module rv64se_dmem (
	input  logic                  clk,
	input  rv64se_pkg::dmem_req_t req,
	output logic [63:0]           rdata
);

	localparam int ROW_W = rv64se_pkg::ROW_W;

	logic [2:0]       off;
	logic [2:0]       off_q;
	logic [ROW_W-1:0] row;
	logic [63:0]      wrot;
	logic [7:0]       bank_rd [8];

	assign off = req.addr[2:0];
	assign row = req.addr[rv64se_pkg::ADDR_W-1:3];

	// byte i of the doubleword lands in bank (off + i) mod 8
	always_comb begin
		logic [2:0] bi;
		wrot = '0;
		for (int i = 0; i < 8; i++) begin
			bi = 3'(i) + off;
			wrot[8*bi +: 8] = req.data[8*i +: 8];
		end
	end

	for (genvar b = 0; b < 8; b++) begin : g_bank
		logic [7:0]       mem [rv64se_pkg::ROWS];
		logic [7:0]       rd_q;
		logic [ROW_W-1:0] brow;

		// banks below the start offset hold the tail in the next row
		assign brow = row + ROW_W'((3'(b) < off) ? 1 : 0);

		always_ff @(posedge clk) begin
			if (req.wr_en) begin
				mem[brow] <= wrot[8*b +: 8];
			end
			if (req.rd_en) begin
				rd_q <= mem[brow];
			end
		end

		assign bank_rd[b] = rd_q;
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			off_q <= off;
		end
	end

	always_comb begin
		logic [2:0] bi;
		rdata = '0;
		for (int i = 0; i < 8; i++) begin
			bi = 3'(i) + off_q;
			rdata[8*i +: 8] = bank_rd[bi];
		end
	end

endmodule

/* sv/rv64se_outq.sv */
// Result queue between the execute stages and the result channel.
module rv64se_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rv64se_pkg::res_t push_data,
	input  logic             pop,
	output logic             not_empty,
	output rv64se_pkg::res_t head
);

	localparam int PW    = rv64se_pkg::OUTQ_PW;
	localparam int CNT_W = rv64se_pkg::CNT_W;

	rv64se_pkg::res_t mem [rv64se_pkg::OUTQ_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* sv/rv64_subset_execute_unit.sv */
// Top level of the RV64I-subset execute unit: decode, execute, pc and sequencing.
// Results: result_valid rises once an item has passed the stage 1 register and the result
//   queue; an in-range LD also passes stage 2, for the registered data memory read.
// Throughput: one item per cycle; an LD in stage 1 holds item_ready low; four in flight max.
// Reset: control clears at once, then a sweep zeroes the data memory banks and register
//   file, one row a cycle, with item_ready low.
module rv64_subset_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         kind,
	input  logic [31:0]        instr_word,
	input  logic [15:0]        address,
	input  logic [63:0]        load_value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         status,
	output logic [15:0]        next_pc,
	output logic               reg_written,
	output logic [4:0]         dest_index,
	output logic signed [63:0] dest_value
);

	localparam int CLR_W = rv64se_pkg::CLR_W;
	localparam int CNT_W = rv64se_pkg::CNT_W;
	localparam int ROW_W = rv64se_pkg::ROW_W;

	// ---- sequencing / reset sweep -------------------------------------------
	logic             clear_q;
	logic [CLR_W-1:0] clr_cnt_q;
	logic [CNT_W-1:0] pending_q;   // items taken in and not yet transferred out
	logic             in_fire;
	logic             out_fire;

	// ---- stage 1: operands back from the register file, execute ------------
	logic                v_s1;
	rv64se_pkg::kind_t   kind_s1;
	logic [31:0]         instr_s1;
	logic [15:0]         addr_s1;
	logic [63:0]         lval_s1;

	// ---- stage 2: load data back from the data memory ----------------------
	logic        v_s2;
	logic [4:0]  rd_s2;
	logic [15:0] npc_s2;

	logic [15:0] pc_q;

	// last register file write, for the read that launched on the same edge
	logic        wb_en_q;
	logic [4:0]  wb_idx_q;
	logic [63:0] wb_data_q;

	// ---- decode ------------------------------------------------------------
	logic [6:0]  opcode;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [63:0] imm_i;
	logic [63:0] imm_s;
	logic [15:0] imm_b;
	logic        s1_is_load;
	logic        is_store;

	logic [63:0] rf_a;
	logic [63:0] rf_b;
	logic [63:0] op_a;
	logic [63:0] op_b;
	logic [63:0] agen;
	logic [63:0] ea;
	logic        ea_ok;
	logic        br_take;

	rv64se_pkg::status_t st_s1;
	logic [15:0]         npc_s1;
	logic                do_wr;
	logic [63:0]         val_s1;
	logic                ld_go;
	logic                st_go;
	logic                pre_go;
	logic                s1_wr;

	rv64se_pkg::rf_wr_t    rf_wr;
	rv64se_pkg::dmem_req_t dreq;
	logic [63:0]           dmem_rdata;
	rv64se_pkg::res_t      res_s1;
	rv64se_pkg::res_t      res_s2;
	rv64se_pkg::res_t      push_data;
	rv64se_pkg::res_t      head;
	logic                  push;

	assign opcode = instr_s1[6:0];
	assign rd     = instr_s1[11:7];
	assign f3     = instr_s1[14:12];
	assign rs1    = instr_s1[19:15];
	assign rs2    = instr_s1[24:20];
	assign f7     = instr_s1[31:25];

	assign imm_i = {{52{instr_s1[31]}}, instr_s1[31:20]};
	assign imm_s = {{52{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
	// B immediate, only the low sixteen bits matter for the pc
	assign imm_b = {{3{instr_s1[31]}}, instr_s1[31], instr_s1[7], instr_s1[30:25],
		instr_s1[11:8], 1'b0};

	// Interlock: an LD in stage 1 keeps the next item out while it is there, so that a
	// dependent instruction never needs load data before it is back.
	assign s1_is_load = v_s1 && (kind_s1 == rv64se_pkg::KIND_EXEC)
		&& (opcode == rv64se_pkg::OP_LOAD) && (f3 == rv64se_pkg::F3_DWORD);

	assign item_ready = !clear_q && !s1_is_load
		&& (pending_q < CNT_W'(rv64se_pkg::OUTQ_DEPTH));
	assign in_fire    = item_valid && item_ready;
	assign out_fire   = result_valid && result_ready;

	// ---- register file, read straight from the input port ------------------
	rv64se_regfile u_regfile (
		.clk (clk),
		.wr  (rf_wr),
		.ra  (instr_word[19:15]),
		.rb  (instr_word[24:20]),
		.rda (rf_a),
		.rdb (rf_b)
	);

	assign op_a = (wb_en_q && (wb_idx_q == rs1)) ? wb_data_q : rf_a;
	assign op_b = (wb_en_q && (wb_idx_q == rs2)) ? wb_data_q : rf_b;

	// ---- address generation and range check --------------------------------
	assign is_store = (opcode == rv64se_pkg::OP_STORE);
	assign agen     = op_a + (is_store ? imm_s : imm_i);
	assign ea       = (kind_s1 == rv64se_pkg::KIND_PRELOAD) ? 64'(addr_s1) : agen;
	assign ea_ok    = (ea <= rv64se_pkg::EA_LIMIT);

	assign br_take = (f3 == rv64se_pkg::F3_BEQ) ? (op_a == op_b)
		: ($signed(op_a) < $signed(op_b));

	// ---- execute ------------------------------------------------------------
	always_comb begin
		st_s1  = rv64se_pkg::ST_EXEC;
		npc_s1 = pc_q + 16'd4;
		do_wr  = 1'b0;
		val_s1 = '0;
		ld_go  = 1'b0;
		st_go  = 1'b0;
		pre_go = 1'b0;
		case (kind_s1)
			rv64se_pkg::KIND_EXEC: begin
				if (instr_s1 == '0) begin
					st_s1  = rv64se_pkg::ST_HALT;
					npc_s1 = pc_q;
				end else if (opcode == rv64se_pkg::OP_REG && f3 == rv64se_pkg::F3_ADD
						&& f7 == rv64se_pkg::F7_ZERO) begin
					val_s1 = op_a + op_b;
					do_wr  = 1'b1;
				end else if (opcode == rv64se_pkg::OP_REG && f3 == rv64se_pkg::F3_ADD
						&& f7 == rv64se_pkg::F7_SUB) begin
					val_s1 = op_a - op_b;
					do_wr  = 1'b1;
				end else if (opcode == rv64se_pkg::OP_IMM && f3 == rv64se_pkg::F3_ADD) begin
					val_s1 = op_a + imm_i;
					do_wr  = 1'b1;
				end else if (opcode == rv64se_pkg::OP_IMM && f3 == rv64se_pkg::F3_SLLI
						&& f7 == rv64se_pkg::F7_ZERO) begin
					val_s1 = op_a << rs2;
					do_wr  = 1'b1;
				end else if (opcode == rv64se_pkg::OP_LOAD
						&& f3 == rv64se_pkg::F3_DWORD) begin
					// write-back happens in stage 2
					if (ea_ok) begin
						ld_go = 1'b1;
					end else begin
						st_s1  = rv64se_pkg::ST_FAULT;
						npc_s1 = pc_q;
					end
				end else if (opcode == rv64se_pkg::OP_STORE
						&& f3 == rv64se_pkg::F3_DWORD) begin
					if (ea_ok) begin
						st_go = 1'b1;
					end else begin
						st_s1  = rv64se_pkg::ST_FAULT;
						npc_s1 = pc_q;
					end
				end else if (opcode == rv64se_pkg::OP_BRANCH
						&& (f3 == rv64se_pkg::F3_BEQ || f3 == rv64se_pkg::F3_BLT)) begin
					if (br_take) begin
						st_s1  = rv64se_pkg::ST_TAKEN;
						npc_s1 = pc_q + imm_b;
					end
				end else begin
					st_s1 = rv64se_pkg::ST_UNSUP;
				end
			end
			rv64se_pkg::KIND_PRELOAD: begin
				npc_s1 = pc_q;
				if (ea_ok) begin
					pre_go = 1'b1;
					st_s1  = rv64se_pkg::ST_DONE;
				end else begin
					st_s1 = rv64se_pkg::ST_FAULT;
				end
			end
			rv64se_pkg::KIND_SETPC: begin
				npc_s1 = addr_s1;
				st_s1  = rv64se_pkg::ST_DONE;
			end
			default: begin
				npc_s1 = pc_q;
				st_s1  = rv64se_pkg::ST_UNSUP;
			end
		endcase
	end

	// writes to x0 are dropped
	assign s1_wr = v_s1 && do_wr && (rd != '0);

	// ---- data memory --------------------------------------------------------
	always_comb begin
		dreq = '0;
		if (clear_q) begin
			dreq.wr_en = (32'(clr_cnt_q) < rv64se_pkg::ROWS);
			dreq.addr  = {clr_cnt_q[ROW_W-1:0], 3'b000};
		end else begin
			dreq.rd_en = v_s1 && ld_go;
			dreq.wr_en = v_s1 && (st_go || pre_go);
			dreq.addr  = ea[rv64se_pkg::ADDR_W-1:0];
			// SD from x0 stores zero
			dreq.data  = pre_go ? lval_s1 : ((rs2 != '0) ? op_b : 64'd0);
		end
	end

	rv64se_dmem u_dmem (
		.clk   (clk),
		.req   (dreq),
		.rdata (dmem_rdata)
	);

	// ---- register write-back: sweep, then load in stage 2, then stage 1 ----
	// A load in stage 2 always has stage 1 empty, so the two never collide.
	always_comb begin
		rf_wr = '0;
		if (clear_q) begin
			rf_wr.en  = (32'(clr_cnt_q) < rv64se_pkg::NREGS);
			rf_wr.idx = clr_cnt_q[4:0];
		end else if (v_s2) begin
			rf_wr.en   = (rd_s2 != '0);
			rf_wr.idx  = rd_s2;
			rf_wr.data = dmem_rdata;
		end else begin
			rf_wr.en   = s1_wr;
			rf_wr.idx  = rd;
			rf_wr.data = val_s1;
		end
	end

	// ---- results ------------------------------------------------------------
	always_comb begin
		res_s1             = '0;
		res_s1.status      = st_s1;
		res_s1.next_pc     = npc_s1;
		res_s1.reg_written = s1_wr;
		res_s1.dest_index  = s1_wr ? rd : 5'd0;
		res_s1.dest_value  = s1_wr ? val_s1 : 64'd0;

		res_s2             = '0;
		res_s2.status      = rv64se_pkg::ST_EXEC;
		res_s2.next_pc     = npc_s2;
		res_s2.reg_written = (rd_s2 != '0);
		res_s2.dest_index  = rd_s2;
		res_s2.dest_value  = (rd_s2 != '0) ? dmem_rdata : 64'd0;
	end

	assign push      = v_s2 || (v_s1 && !ld_go);
	assign push_data = v_s2 ? res_s2 : res_s1;

	// queue never overflows: item_ready counts every item still in flight
	rv64se_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (out_fire),
		.not_empty (result_valid),
		.head      (head)
	);

	assign status      = head.status;
	assign next_pc     = head.next_pc;
	assign reg_written = head.reg_written;
	assign dest_index  = head.dest_index;
	assign dest_value  = $signed(head.dest_value);

	// ---- control registers --------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
			pending_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			pc_q      <= '0;
			wb_en_q   <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + CLR_W'(1);
				if (clr_cnt_q == CLR_W'(rv64se_pkg::CLEAR_CYCLES - 1)) begin
					clear_q <= 1'b0;
				end
			end
			pending_q <= pending_q + CNT_W'(in_fire) - CNT_W'(out_fire);
			v_s1      <= in_fire;
			v_s2      <= v_s1 && ld_go;
			if (v_s1) begin
				pc_q <= npc_s1;
			end
			wb_en_q <= rf_wr.en;
		end
	end

	// ---- payload registers --------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= rv64se_pkg::kind_t'(kind);
			instr_s1 <= instr_word;
			addr_s1  <= address;
			lval_s1  <= load_value;
		end
		if (v_s1) begin
			rd_s2  <= rd;
			npc_s2 <= npc_s1;
		end
		wb_idx_q  <= rf_wr.idx;
		wb_data_q <= rf_wr.data;
	end

	// ---- assertions ---------------------------------------------------------
	// load interlock: stage 2 busy means stage 1 is empty
	a_ld_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !v_s1)
		else $error("load in stage 2 overlaps an item in stage 1");

	// in-flight count stays within the queue depth
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(rv64se_pkg::OUTQ_DEPTH))
		else $error("more items in flight than the result queue holds");

	// a result on the port belongs to an item still counted in flight
	a_result_owned: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pending_q != '0))
		else $error("result offered with no item in flight");

	// x0 is only written by the reset sweep
	a_x0_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(rf_wr.en && !clear_q) |-> (rf_wr.idx != '0))
		else $error("register x0 written");

endmodule

/* verif/testbench.sv */
// Self-checking testbench of the RV64I-subset execute unit, with its own architectural model.
module testbench;
	import rv64se_pkg::*;

	localparam int ITEM_TARGET = 1950;

	typedef struct {
		kind_t       kind;
		logic [31:0] instr;
		logic [15:0] addr;
		logic [63:0] value;
		int          gap;
	} item_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	logic [1:0]         kind         = '0;
	logic [31:0]        instr_word   = '0;
	logic [15:0]        address      = '0;
	logic [63:0]        load_value   = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [2:0]         status;
	logic [15:0]        next_pc;
	logic               reg_written;
	logic [4:0]         dest_index;
	logic signed [63:0] dest_value;

	// Architectural state as the testbench sees it: registers, data memory, pc.
	logic [63:0] arch_regs [NREGS]      = '{default: '0};
	logic [7:0]  arch_mem  [DATA_BYTES] = '{default: '0};
	logic [15:0] arch_pc                = '0;

	item_t item_q[$];      // items waiting to be offered
	res_t  outcome_q[$];   // outcomes of accepted items, oldest first
	item_t cur_item;
	int    idle_cnt     = 0;
	int    tx_calm      = 0;
	int    rx_calm      = 0;
	int    hold_cnt     = 0;
	int    hold_len     = 0;
	int    mismatch_cnt = 0;

	rv64_subset_execute_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.instr_word   (instr_word),
		.address      (address),
		.load_value   (load_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.next_pc      (next_pc),
		.reg_written  (reg_written),
		.dest_index   (dest_index),
		.dest_value   (dest_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Applies one item to the architectural state and returns the outcome it must give.
	function automatic res_t execute_item(input item_t it);
		res_t        r;
		logic [31:0] w;
		logic [6:0]  opc, f7;
		logic [4:0]  rd, rs1, rs2;
		logic [2:0]  f3;
		logic [63:0] a, b, imm_i, imm_s, imm_b, ea, val;
		logic        wr_en, take;
		w     = it.instr;
		opc   = w[6:0];
		rd    = w[11:7];
		f3    = w[14:12];
		rs1   = w[19:15];
		rs2   = w[24:20];
		f7    = w[31:25];
		a     = arch_regs[rs1];
		b     = arch_regs[rs2];
		imm_i = {{52{w[31]}}, w[31:20]};
		imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		val   = '0;
		wr_en = 1'b0;
		r.status      = ST_EXEC;
		r.next_pc     = arch_pc;
		r.reg_written = 1'b0;
		r.dest_index  = '0;
		r.dest_value  = '0;
		case (it.kind)
		KIND_EXEC: begin
			r.next_pc = arch_pc + 16'd4;
			if (w == '0) begin
				r.status  = ST_HALT;
				r.next_pc = arch_pc;
			end else if (opc == OP_REG && f3 == F3_ADD && f7 == F7_ZERO) begin
				val   = a + b;
				wr_en = 1'b1;
			end else if (opc == OP_REG && f3 == F3_ADD && f7 == F7_SUB) begin
				val   = a - b;
				wr_en = 1'b1;
			end else if (opc == OP_IMM && f3 == F3_ADD) begin
				val   = a + imm_i;
				wr_en = 1'b1;
			end else if (opc == OP_IMM && f3 == F3_SLLI && f7 == F7_ZERO) begin
				val   = a << rs2;
				wr_en = 1'b1;
			end else if (opc == OP_LOAD && f3 == F3_DWORD) begin
				ea = a + imm_i;
				if (ea > EA_LIMIT) begin
					r.status  = ST_FAULT;
					r.next_pc = arch_pc;
				end else begin
					for (int i = 0; i < 8; i++)
						val[8*i +: 8] = arch_mem[int'(ea) + i];
					wr_en = 1'b1;
				end
			end else if (opc == OP_STORE && f3 == F3_DWORD) begin
				ea = a + imm_s;
				if (ea > EA_LIMIT) begin
					r.status  = ST_FAULT;
					r.next_pc = arch_pc;
				end else begin
					for (int i = 0; i < 8; i++)
						arch_mem[int'(ea) + i] = (rs2 != 5'd0) ? b[8*i +: 8] : 8'h00;
				end
			end else if (opc == OP_BRANCH && (f3 == F3_BEQ || f3 == F3_BLT)) begin
				take = (f3 == F3_BEQ) ? (a == b) : ($signed(a) < $signed(b));
				if (take) begin
					r.status  = ST_TAKEN;
					r.next_pc = arch_pc + imm_b[15:0];
				end
			end else begin
				r.status = ST_UNSUP;
			end
			if (wr_en && rd != 5'd0) begin
				arch_regs[rd] = val;
				r.reg_written = 1'b1;
				r.dest_index  = rd;
				r.dest_value  = val;
			end
		end
		KIND_PRELOAD: begin
			if ({48'd0, it.addr} > EA_LIMIT) begin
				r.status = ST_FAULT;
			end else begin
				for (int i = 0; i < 8; i++)
					arch_mem[int'(it.addr) + i] = it.value[8*i +: 8];
				r.status = ST_DONE;
			end
		end
		KIND_SETPC: begin
			r.next_pc = it.addr;
			r.status  = ST_DONE;
		end
		default: r.status = ST_UNSUP;
		endcase
		arch_pc = r.next_pc;
		return r;
	endfunction

	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
			input logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
			input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1);
		return {imm[11:5], rs2, rs1, F3_DWORD, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
	endfunction

	// Gap before the item; now and then a run of back-to-back items.
	task automatic push_item(input kind_t k, input logic [31:0] w, input logic [15:0] adr,
			input logic [63:0] v);
		item_t it;
		it.kind  = k;
		it.instr = w;
		it.addr  = adr;
		it.value = v;
		if (tx_calm > 0) begin
			tx_calm--;
			it.gap = 0;
		end else begin
			it.gap = $urandom_range(0, 14);
			if ($urandom_range(0, 19) == 0)
				tx_calm = $urandom_range(10, 60);
		end
		item_q.insert(item_q.size(), it);
	endtask

	task automatic push_exec(input logic [31:0] w);
		push_item(KIND_EXEC, w, 16'($urandom), {$urandom, $urandom});
	endtask

	// Stimulus: directed corner cases, then random sequences.
	initial begin : stim
		logic [4:0]  xb, rx, r1, r2;
		logic [11:0] k, j;
		logic [2:0]  s;
		logic [6:0]  opc;
		logic [63:0] base, ea;
		int          off;

		push_exec(32'h0000_0000);                                    // halt, pc holds
		push_exec(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1, OP_IMM));       // x1 = -1
		push_exec(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OP_IMM));       // x2 = 2047
		push_exec(enc_i(12'd5, 5'd1, F3_ADD, 5'd0, OP_IMM));         // write to x0 dropped
		push_exec(enc_r(F7_ZERO, 5'd2, 5'd1, F3_ADD, 5'd3, OP_REG));
		push_exec(enc_r(F7_SUB, 5'd2, 5'd0, F3_ADD, 5'd4, OP_REG));
		push_exec(enc_i({F7_ZERO, 5'd31}, 5'd1, F3_SLLI, 5'd5, OP_IMM));
		push_exec(enc_i({F7_SUB, 5'd3}, 5'd1, F3_SLLI, 5'd6, OP_IMM)); // bad funct7
		push_exec(enc_r(F7_ZERO, 5'd2, 5'd1, F3_SLLI, 5'd6, OP_REG));  // bad funct3
		push_item(KIND_PRELOAD, '0, 16'd0, 64'h8000_0000_0000_0001);
		push_item(KIND_PRELOAD, '1, 16'(DATA_BYTES - 8), '1);        // top doubleword
		push_item(KIND_PRELOAD, '0, 16'hFFFF, 64'h0123_4567_89AB_CDEF); // past the end
		push_exec(enc_i(12'd0, 5'd0, F3_DWORD, 5'd7, OP_LOAD));
		// x8 = 65528, the highest legal doubleword address
		push_exec(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd8, OP_IMM));
		push_exec(enc_i({F7_ZERO, 5'd5}, 5'd8, F3_SLLI, 5'd8, OP_IMM));
		push_exec(enc_i(12'd24, 5'd8, F3_ADD, 5'd8, OP_IMM));
		push_exec(enc_i(12'd0, 5'd8, F3_DWORD, 5'd9, OP_LOAD));
		push_exec(enc_i(12'd1, 5'd8, F3_DWORD, 5'd9, OP_LOAD));      // one byte too far
		push_exec(enc_s(12'd0, 5'd0, 5'd8));                         // store from x0
		push_exec(enc_i(12'd0, 5'd8, F3_DWORD, 5'd10, OP_LOAD));
		push_exec(enc_i(12'hFF8, 5'd0, F3_DWORD, 5'd11, OP_LOAD));   // negative address
		push_item(KIND_SETPC, '0, 16'hFFFC, '0);
		push_exec(enc_b(13'd8, 5'd0, 5'd0, F3_BEQ));                 // taken, pc wraps
		push_exec(enc_b(13'h1000, 5'd2, 5'd1, F3_BLT));              // signed compare, -4096
		push_item(KIND_RSVD, '1, '1, '1);

		while (item_q.size() < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: begin
				// Build a base register, then preloads, loads and stores around it.
				xb = 5'($urandom_range(1, 31));
				if ($urandom_range(0, 4) == 0) begin
					k = 12'd2047;
					s = 3'd5;
					j = 12'($urandom_range(0, 40));
				end else begin
					k = 12'($urandom_range(0, 2047));
					s = 3'($urandom_range(0, 5));
					j = 12'($urandom);
				end
				push_exec(enc_i(k, 5'd0, F3_ADD, xb, OP_IMM));
				push_exec(enc_i({F7_ZERO, 2'b00, s}, xb, F3_SLLI, xb, OP_IMM));
				push_exec(enc_i(j, xb, F3_ADD, xb, OP_IMM));
				base = (64'(k) << s) + {{52{j[11]}}, j};
				repeat ($urandom_range(2, 8)) begin
					if ($urandom_range(0, 7) == 0)
						off = int'($signed(12'($urandom)));
					else
						off = 8 * $urandom_range(0, 8) - 32;
					ea = base + 64'(off);
					case ($urandom_range(0, 2))
					0: push_item(KIND_PRELOAD, $urandom, ea[15:0], {$urandom, $urandom});
					1: begin
						do rx = 5'($urandom); while (rx == xb);
						push_exec(enc_i(12'(off), xb, F3_DWORD, rx, OP_LOAD));
					end
					default: push_exec(enc_s(12'(off), 5'($urandom), xb));
					endcase
				end
			end
			8, 9, 10, 11, 12: begin
				repeat ($urandom_range(1, 4)) begin
					rx = 5'($urandom);
					r1 = 5'($urandom);
					r2 = 5'($urandom);
					case ($urandom_range(0, 3))
					0: push_exec(enc_r(F7_ZERO, r2, r1, F3_ADD, rx, OP_REG));
					1: push_exec(enc_r(F7_SUB, r2, r1, F3_ADD, rx, OP_REG));
					2: push_exec(enc_i(12'($urandom), r1, F3_ADD, rx, OP_IMM));
					default: push_exec(enc_i({F7_ZERO, r2}, r1, F3_SLLI, rx, OP_IMM));
					endcase
				end
			end
			13, 14, 15: begin
				r1 = 5'($urandom);
				r2 = ($urandom_range(0, 2) == 0) ? r1 : 5'($urandom);
				push_exec(enc_b({12'($urandom), 1'b0}, r2, r1,
					($urandom_range(0, 1) == 0) ? F3_BEQ : F3_BLT));
			end
			16, 17: begin
				if ($urandom_range(0, 1) == 0)
					push_item(KIND_SETPC, $urandom, 16'($urandom), {$urandom, $urandom});
				else
					push_item(KIND_PRELOAD, $urandom, 16'($urandom), {$urandom, $urandom});
			end
			default: begin
				case ($urandom_range(0, 4))
				0: push_exec($urandom);
				1: push_item(KIND_RSVD, $urandom, 16'($urandom), {$urandom, $urandom});
				2: push_exec(32'h0000_0000);
				default: begin
					// right opcode, random funct fields
					case ($urandom_range(0, 4))
					0: opc = OP_REG;
					1: opc = OP_IMM;
					2: opc = OP_LOAD;
					3: opc = OP_STORE;
					default: opc = OP_BRANCH;
					endcase
					push_exec({25'($urandom), opc});
				end
				endcase
			end
			endcase
		end
	end

	// Driver: offers the queued items in order; the outcome is worked out on each transfer.
	always @(posedge clk or negedge arst_n) begin : drv
		logic vld;
		if (!arst_n) begin
			item_valid <= 1'b0;
			idle_cnt = 0;
		end else begin
			vld = item_valid;
			if (item_valid && item_ready) begin
				outcome_q.insert(outcome_q.size(), execute_item(cur_item));
				vld = 1'b0;
			end
			if (!vld && item_q.size() != 0) begin
				if (idle_cnt < item_q[0].gap) begin
					idle_cnt++;
				end else begin
					cur_item = item_q.pop_front();
					idle_cnt = 0;
					vld = 1'b1;
					kind       <= cur_item.kind;
					instr_word <= cur_item.instr;
					address    <= cur_item.addr;
					load_value <= cur_item.value;
				end
			end
			item_valid <= vld;
		end
	end

	function automatic void field_check(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			$display("%0t %s mismatch: expected %h, actual %h", $time, fname, want, got);
		end
	endfunction

	// Monitor: stalls result_ready at random, checks each transfer against the oldest outcome.
	always @(posedge clk or negedge arst_n) begin : mon
		res_t want;
		logic rdy;
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_cnt = 0;
			hold_len = 0;
		end else begin
			rdy = result_ready;
			if (result_valid && result_ready) begin
				if (outcome_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t unexpected result: expected none, actual status %0d next_pc %h",
						$time, status, next_pc);
				end else begin
					want = outcome_q.pop_front();
					field_check("status", 64'(want.status), 64'(status));
					field_check("next_pc", 64'(want.next_pc), 64'(next_pc));
					field_check("reg_written", 64'(want.reg_written), 64'(reg_written));
					field_check("dest_index", 64'(want.dest_index), 64'(dest_index));
					field_check("dest_value", want.dest_value, dest_value);
				end
				rdy = 1'b0;
				hold_cnt = 0;
				if (rx_calm > 0) begin
					rx_calm--;
					hold_len = 0;
				end else begin
					hold_len = $urandom_range(0, 14);
					if ($urandom_range(0, 19) == 0)
						rx_calm = $urandom_range(10, 60);
				end
			end
			if (!rdy) begin
				if (hold_cnt >= hold_len)
					rdy = 1'b1;
				else
					hold_cnt++;
			end
			result_ready <= rdy;
		end
	end

	// End of test: all items offered and accepted, all outcomes seen, then a short drain.
	initial begin : finish_ctl
		wait (arst_n);
		@(posedge clk);
		while (item_q.size() != 0 || item_valid)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: covers the reset clearing sweep plus the slowest legal run several times over.
	initial begin : watchdog
		#6000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
